// ===== src/dar_pkg.sv =====
// Package for the dual-alias range classifier.
// Holds the request, token and code types shared by the cells and the top level.
// No dependencies.
package dar_pkg;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_CLASSIFY   = 2'd2,
    ACT_NONE       = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_WRITE   = 2'd1,
    CLS_EXEC    = 2'd2
  } cls_t;

  // The request held at the top level and seen by every cell.
  typedef struct packed {
    act_t        action;
    logic [63:0] write_base;
    logic [63:0] exec_base;
    logic [31:0] region_bytes;
    logic [31:0] remove_id;
    logic [63:0] query_address;
    logic [31:0] new_id;
  } req_t;

  // The token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic        done;
    cls_t        cls;
    logic [31:0] id;
    logic [31:0] offset;
    logic [63:0] other_base;
  } token_t;

endpackage

// ===== src/dar_if.sv =====
// Channel interfaces for the dual-alias range classifier.
// Depends on nothing; carries valid, ready and the payload of each channel.
interface dar_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] write_base;
  logic [63:0] exec_base;
  logic [31:0] region_bytes;
  logic [31:0] remove_id;
  logic [63:0] query_address;

  modport source (output valid, action, write_base, exec_base, region_bytes, remove_id,
                  query_address, input ready);
  modport sink (input valid, action, write_base, exec_base, region_bytes, remove_id,
                query_address, output ready);
endinterface

interface dar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  region_class;
  logic [31:0] hit_id;
  logic [31:0] hit_offset;
  logic [63:0] alias_address;
  logic [31:0] assigned_id;
  logic        table_full;

  modport source (output valid, region_class, hit_id, hit_offset, alias_address, assigned_id,
                  table_full, input ready);
  modport sink (input valid, region_class, hit_id, hit_offset, alias_address, assigned_id,
                table_full, output ready);
endinterface

// ===== src/dar_cell.sv =====
// One table slot of the dual-alias range classifier and its stage of the token chain.
// Depends on dar_pkg.
module dar_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dar_pkg::req_t   req,
  input  dar_pkg::token_t tok_in,
  output dar_pkg::token_t tok_out
);
  import dar_pkg::*;

  logic [63:0] wbase_r;
  logic [63:0] xbase_r;
  logic [31:0] bytes_r;
  logic [31:0] id_r;
  token_t      tok_r;
  token_t      tok_nxt;

  logic [64:0] dw;
  logic [64:0] dx;
  logic        hit_w;
  logic        hit_x;
  logic        active;
  logic        take;

  always_comb begin
    dw = {1'b0, req.query_address} - {1'b0, wbase_r};
    dx = {1'b0, req.query_address} - {1'b0, xbase_r};
    hit_w = !dw[64] && (dw[63:32] == 32'd0) && (dw[31:0] < bytes_r);
    hit_x = !dx[64] && (dx[63:32] == 32'd0) && (dx[31:0] < bytes_r);
    active = tok_in.valid && !tok_in.done;
    case (req.action)
      ACT_REGISTER:   take = (bytes_r == 32'd0);
      ACT_UNREGISTER: take = (id_r == req.remove_id);
      ACT_CLASSIFY:   take = hit_w || hit_x;
      default:        take = 1'b0;
    endcase
    tok_nxt = tok_in;
    if (active && take) begin
      tok_nxt.done = 1'b1;
      if (req.action == ACT_CLASSIFY) begin
        tok_nxt.id = id_r;
        if (hit_w) begin
          tok_nxt.cls        = CLS_WRITE;
          tok_nxt.offset     = dw[31:0];
          tok_nxt.other_base = xbase_r;
        end else begin
          tok_nxt.cls        = CLS_EXEC;
          tok_nxt.offset     = dx[31:0];
          tok_nxt.other_base = wbase_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      bytes_r <= '0;
      id_r    <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (active && take && req.action == ACT_REGISTER) begin
        bytes_r <= req.region_bytes;
        id_r    <= req.new_id;
      end else if (active && take && req.action == ACT_UNREGISTER) begin
        bytes_r <= '0;
        id_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && take && req.action == ACT_REGISTER) begin
      wbase_r <= req.write_base;
      xbase_r <= req.exec_base;
    end else if (active && take && req.action == ACT_UNREGISTER) begin
      wbase_r <= '0;
      xbase_r <= '0;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/dual_alias_range_classifier.sv =====
// Top level of the dual-alias range classifier: request register, id counter,
// the chain of dar_cell slots and the result register. Depends on dar_pkg and dar_if.
//
//   channel | direction | contents
//   in_ch   | sink      | action, both bases, size, id to remove, address to classify
//   out_ch  | source    | class, id, offset, other alias, assigned id, full flag
//
// One request is in flight at a time; its result is set by a token that starts when the
// request is accepted and visits one slot per cycle down the chain.
// A new request is accepted once the previous result has been taken.
// Reset is synchronous and empties every slot and sets the id counter to one.
// A stalled result holds in the output register and blocks new requests.
module dual_alias_range_classifier #(
  parameter int ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  dar_in_if.sink    in_ch,
  dar_out_if.source out_ch
);
  import dar_pkg::*;

  req_t        req_r;
  logic        busy_r;
  logic        start_r;
  logic [31:0] next_id_r;
  logic [31:0] draw_id;
  token_t      tok_head;
  token_t      tok [ENTRIES];
  token_t      tok_last;
  logic [ENTRIES-1:0] tok_valid;

  logic        out_valid_r;
  logic [1:0]  out_class_r;
  logic [31:0] out_hit_id_r;
  logic [31:0] out_offset_r;
  logic [63:0] out_other_r;
  logic [31:0] out_assigned_r;
  logic        out_full_r;

  logic in_acc;
  logic out_acc;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign out_acc     = out_valid_r && out_ch.ready;
  assign draw_id     = (next_id_r == 32'd0) ? 32'd1 : next_id_r;

  always_comb begin
    tok_head       = '0;
    tok_head.valid = start_r;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      dar_cell u_cell (.clk, .rst_n, .req(req_r), .tok_in(tok_head), .tok_out(tok[i]));
    end else begin : g_rest
      dar_cell u_cell (.clk, .rst_n, .req(req_r), .tok_in(tok[i-1]), .tok_out(tok[i]));
    end
    assign tok_valid[i] = tok[i].valid;
  end

  assign tok_last = tok[ENTRIES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_acc;
      if (in_acc) begin
        busy_r <= 1'b1;
        if (act_t'(in_ch.action) == ACT_REGISTER) begin
          next_id_r <= draw_id + 32'd1;
        end
      end else if (out_acc) begin
        busy_r <= 1'b0;
      end
      if (tok_last.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.action        <= act_t'(in_ch.action);
      req_r.write_base    <= in_ch.write_base;
      req_r.exec_base     <= in_ch.exec_base;
      req_r.region_bytes  <= in_ch.region_bytes;
      req_r.remove_id     <= in_ch.remove_id;
      req_r.query_address <= in_ch.query_address;
      req_r.new_id        <= draw_id;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_last.valid) begin
      out_class_r    <= 2'd0;
      out_hit_id_r   <= 32'd0;
      out_offset_r   <= 32'd0;
      out_other_r    <= 64'd0;
      out_assigned_r <= 32'd0;
      out_full_r     <= 1'b0;
      case (req_r.action)
        ACT_REGISTER: begin
          out_assigned_r <= req_r.new_id;
          out_full_r     <= !tok_last.done;
        end
        ACT_CLASSIFY: begin
          if (tok_last.done) begin
            out_class_r  <= tok_last.cls;
            out_hit_id_r <= tok_last.id;
            out_offset_r <= tok_last.offset;
            out_other_r  <= tok_last.other_base + {32'd0, tok_last.offset};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.region_class  = out_class_r;
  assign out_ch.hit_id        = out_hit_id_r;
  assign out_ch.hit_offset    = out_offset_r;
  assign out_ch.alias_address = out_other_r;
  assign out_ch.assigned_id   = out_assigned_r;
  assign out_ch.table_full    = out_full_r;

  // Only one token may travel the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_valid, start_r}))
    else $error("more than one token in the chain");

  // A request is only taken when the chain and the output register are empty.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (tok_valid == '0) && !start_r && !out_valid_r)
    else $error("request accepted while another is in flight");

  // The full flag is only raised for a register request.
  a_full_register: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> req_r.action == ACT_REGISTER)
    else $error("table full reported for a non-register request");

  // A hit is only reported for a classify request.
  a_class_classify: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_class_r != CLS_OUTSIDE |-> req_r.action == ACT_CLASSIFY)
    else $error("address class reported for a non-classify request");

  // The token leaves the last cell exactly when the result register fills.
  a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |=> out_valid_r)
    else $error("result register did not capture the token");

endmodule

// ===== verif/tb.sv =====
// Testbench for dual_alias_range_classifier: directed table, then random register, unregister
// and classify traffic with bursty requests and a stalling receiver, checked by a region table.
// Depends on dar_pkg, the dar_in_if and dar_out_if interfaces and the top level under src.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dar_pkg::*;

  localparam int ENTRIES = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    act_t        action;
    logic [63:0] write_base;
    logic [63:0] exec_base;
    logic [31:0] region_bytes;
    logic [31:0] remove_id;
    logic [63:0] query_address;
  } alias_req_t;

  typedef struct {
    cls_t        cls;
    logic [31:0] hit_id;
    logic [31:0] hit_offset;
    logic [63:0] alias_address;
    logic [31:0] assigned_id;
    logic        table_full;
  } alias_res_t;

  typedef struct {
    alias_req_t req;
    bit         typed_in;
    alias_res_t res;
  } stim_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dar_in_if  in_ch ();
  dar_out_if out_ch ();

  dual_alias_range_classifier #(.ENTRIES(ENTRIES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5ns clk = ~clk;

  logic [63:0] tab_wbase [ENTRIES];
  logic [63:0] tab_xbase [ENTRIES];
  logic [31:0] tab_bytes [ENTRIES];
  logic [31:0] tab_id    [ENTRIES];
  logic [31:0] id_counter;

  alias_res_t alias_result_q [$];
  stim_row_t  dir_rows [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;

  function automatic alias_req_t mk_req(act_t a, logic [63:0] wb, logic [63:0] xb,
                                        logic [31:0] n, logic [31:0] rid, logic [63:0] addr);
    alias_req_t r;
    r.action = a;
    r.write_base = wb;
    r.exec_base = xb;
    r.region_bytes = n;
    r.remove_id = rid;
    r.query_address = addr;
    return r;
  endfunction

  function automatic alias_res_t mk_res(cls_t c, logic [31:0] id, logic [31:0] off,
                                        logic [63:0] other, logic [31:0] asg, logic full);
    alias_res_t r;
    r.cls = c;
    r.hit_id = id;
    r.hit_offset = off;
    r.alias_address = other;
    r.assigned_id = asg;
    r.table_full = full;
    return r;
  endfunction

  function automatic bit holds(logic [63:0] addr, logic [63:0] base, logic [31:0] n);
    return (addr >= base) && ((addr - base) < {32'd0, n});
  endfunction

  // Applies one request to the region table and returns the result it produces.
  function automatic alias_res_t alias_table_step(alias_req_t r);
    alias_res_t  res;
    logic [31:0] id;
    logic [63:0] off;
    bit          done;
    res = mk_res(CLS_OUTSIDE, '0, '0, '0, '0, 1'b0);
    done = 1'b0;
    case (r.action)
      ACT_REGISTER: begin
        id = id_counter;
        id_counter = id_counter + 32'd1;
        if (id == 32'd0) begin
          id = id_counter;
          id_counter = id_counter + 32'd1;
        end
        res.assigned_id = id;
        res.table_full = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && tab_bytes[i] == 32'd0) begin
            tab_wbase[i] = r.write_base;
            tab_xbase[i] = r.exec_base;
            tab_bytes[i] = r.region_bytes;
            tab_id[i] = id;
            res.table_full = 1'b0;
            done = 1'b1;
          end
        end
      end
      ACT_UNREGISTER: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && tab_id[i] == r.remove_id) begin
            tab_wbase[i] = '0;
            tab_xbase[i] = '0;
            tab_bytes[i] = '0;
            tab_id[i] = '0;
            done = 1'b1;
          end
        end
      end
      ACT_CLASSIFY: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && tab_bytes[i] != 32'd0) begin
            if (holds(r.query_address, tab_wbase[i], tab_bytes[i])) begin
              off = r.query_address - tab_wbase[i];
              res = mk_res(CLS_WRITE, tab_id[i], off[31:0], tab_xbase[i] + off, '0, 1'b0);
              done = 1'b1;
            end else if (holds(r.query_address, tab_xbase[i], tab_bytes[i])) begin
              off = r.query_address - tab_xbase[i];
              res = mk_res(CLS_EXEC, tab_id[i], off[31:0], tab_wbase[i] + off, '0, 1'b0);
              done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand_base();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {32'd0, $urandom & 32'hFFFF_F000};
      2: return {32'hFFFF_FFFF, $urandom};
      default: return 64'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic logic [31:0] rand_bytes();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      4: return $urandom_range(1, 1 << 20);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic int live_slot();
    int start;
    int idx;
    start = $urandom_range(0, ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++) begin
      idx = (start + k) % ENTRIES;
      if (tab_bytes[idx] != 32'd0) return idx;
    end
    return -1;
  endfunction

  function automatic logic [31:0] rand_remove_id();
    int s;
    s = live_slot();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return id_counter - 32'($urandom_range(1, 3));
      default: return (s >= 0) ? tab_id[s] : $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_query();
    int          s;
    logic [63:0] base;
    logic [31:0] n;
    logic [63:0] off;
    s = live_slot();
    if (s < 0 || $urandom_range(0, 4) == 0) return {$urandom, $urandom};
    base = ($urandom_range(0, 1) == 0) ? tab_wbase[s] : tab_xbase[s];
    n = tab_bytes[s];
    case ($urandom_range(0, 5))
      0: off = 64'd0;
      1: off = {32'd0, n} - 64'd1;
      2: off = {32'd0, n};
      3: off = '1;
      default: off = 64'($urandom_range(0, n - 32'd1));
    endcase
    return base + off;
  endfunction

  function automatic alias_req_t rand_request(traffic_mix_t mix);
    alias_req_t r;
    int         pick;
    int         reg_pct;
    int         unreg_pct;
    int         cls_pct;
    r = mk_req(ACT_NONE, rand_base(), rand_base(), rand_bytes(), $urandom,
               {$urandom, $urandom});
    case (mix)
      MIX_FILL: begin
        reg_pct = 60; unreg_pct = 70; cls_pct = 97;
      end
      MIX_DRAIN: begin
        reg_pct = 10; unreg_pct = 65; cls_pct = 97;
      end
      default: begin
        reg_pct = 30; unreg_pct = 55; cls_pct = 97;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < reg_pct) begin
      r.action = ACT_REGISTER;
    end else if (pick < unreg_pct) begin
      r.action = ACT_UNREGISTER;
      r.remove_id = rand_remove_id();
    end else if (pick < cls_pct) begin
      r.action = ACT_CLASSIFY;
      r.query_address = rand_query();
    end
    return r;
  endfunction

  // Requests go out in bursts; a gap before a burst leaves valid low for a random time.
  task automatic send_request(alias_req_t r, bit typed_in, alias_res_t typed_res);
    alias_res_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 80)) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= r.action;
    in_ch.write_base <= r.write_base;
    in_ch.exec_base <= r.exec_base;
    in_ch.region_bytes <= r.region_bytes;
    in_ch.remove_id <= r.remove_id;
    in_ch.query_address <= r.query_address;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = alias_table_step(r);
    alias_result_q.push_back(typed_in ? typed_res : predicted);
  endtask

  initial begin : receiver_stalls
    out_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(20, 200)) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
        1: repeat ($urandom_range(20, 200)) begin
          @(negedge clk);
          out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
        2: repeat ($urandom_range(1, 40)) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
        default: repeat ($urandom_range(20, 200)) begin
          @(negedge clk);
          out_ch.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    alias_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (alias_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: cls=%0d id=%h off=%h other=%h asg=%h full=%b",
                   out_ch.region_class, out_ch.hit_id, out_ch.hit_offset,
                   out_ch.alias_address, out_ch.assigned_id, out_ch.table_full);
      end else begin
        want = alias_result_q.pop_front();
        if (out_ch.region_class !== want.cls || out_ch.hit_id !== want.hit_id ||
            out_ch.hit_offset !== want.hit_offset ||
            out_ch.alias_address !== want.alias_address ||
            out_ch.assigned_id !== want.assigned_id || out_ch.table_full !== want.table_full)
        begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: want cls=%0d id=%h off=%h other=%h asg=%h full=%b",
                     want.cls, want.hit_id, want.hit_offset, want.alias_address,
                     want.assigned_id, want.table_full);
            $display("          got  cls=%0d id=%h off=%h other=%h asg=%h full=%b",
                     out_ch.region_class, out_ch.hit_id, out_ch.hit_offset,
                     out_ch.alias_address, out_ch.assigned_id, out_ch.table_full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    alias_req_t   r;
    alias_res_t   none;
    traffic_mix_t mix;
    int           episode_left;
    int           sent;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.write_base = '0;
    in_ch.exec_base = '0;
    in_ch.region_bytes = '0;
    in_ch.remove_id = '0;
    in_ch.query_address = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tab_wbase[i] = '0;
      tab_xbase[i] = '0;
      tab_bytes[i] = '0;
      tab_id[i] = '0;
    end
    id_counter = 32'd1;
    none = mk_res(CLS_OUTSIDE, '0, '0, '0, '0, 1'b0);

    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, '0), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_REGISTER, 64'h1000, 64'h8000_0000_0000_1000, 32'h100,
                                '0, '0), 1'b1, mk_res(CLS_OUTSIDE, '0, '0, '0, 32'd1, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h1000), 1'b1,
                         mk_res(CLS_WRITE, 32'd1, 32'h0, 64'h8000_0000_0000_1000, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h10FF), 1'b1,
                         mk_res(CLS_WRITE, 32'd1, 32'hFF, 64'h8000_0000_0000_10FF, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h1100), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h0FFF), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h8000_0000_0000_1080), 1'b1,
                         mk_res(CLS_EXEC, 32'd1, 32'h80, 64'h1080, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, '0, 32'hFFFF_FFFF,
                                '0, '0), 1'b1, mk_res(CLS_OUTSIDE, '0, '0, '0, 32'd2, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
                         mk_res(CLS_WRITE, 32'd2, 32'hFF, 64'hFF, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, '0), 1'b1,
                         mk_res(CLS_EXEC, 32'd2, 32'h0, 64'hFFFF_FFFF_FFFF_FF00, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'hFFFF_FFFF), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_REGISTER, 64'h5000, 64'h6000, 32'd0, '0, '0), 1'b1,
                         mk_res(CLS_OUTSIDE, '0, '0, '0, 32'd3, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h5000), 1'b0, none});
    dir_rows.push_back('{mk_req(ACT_REGISTER, 64'h5000, 64'h6000, 32'h10, '0, '0), 1'b1,
                         mk_res(CLS_OUTSIDE, '0, '0, '0, 32'd4, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_UNREGISTER, '0, '0, '0, 32'd2, '0), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h6008), 1'b1,
                         mk_res(CLS_EXEC, 32'd4, 32'h8, 64'h5008, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_UNREGISTER, '0, '0, '0, 32'd0, '0), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_UNREGISTER, '0, '0, '0, 32'hFFFF_FFFF, '0), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_NONE, '1, '1, '1, '1, '1), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_REGISTER, 64'h9000, 64'h9000, 32'h20, '0, '0), 1'b1,
                         mk_res(CLS_OUTSIDE, '0, '0, '0, 32'd5, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h901F), 1'b1,
                         mk_res(CLS_WRITE, 32'd5, 32'h1F, 64'h901F, '0, 1'b0)});
    dir_rows.push_back('{mk_req(ACT_REGISTER, '1, '1, 32'd1, '1, '1), 1'b0, none});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, '1), 1'b0, none});
    dir_rows.push_back('{mk_req(ACT_UNREGISTER, '0, '0, '0, 32'd1, '0), 1'b1, none});
    dir_rows.push_back('{mk_req(ACT_CLASSIFY, '0, '0, '0, '0, 64'h1000), 1'b0, none});

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed_in, dir_rows[k].res);

    // Register-heavy episodes fill the table past full; drain episodes empty it again.
    sent = 0;
    episode_left = 0;
    mix = MIX_BALANCED;
    while (sent < RANDOM_ITEMS) begin
      if (episode_left == 0) begin
        mix = traffic_mix_t'($urandom_range(0, 2));
        episode_left = $urandom_range(40, 160);
      end
      episode_left--;
      r = rand_request(mix);
      send_request(r, 1'b0, none);
      if (r.action != ACT_NONE) sent++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (alias_result_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
